// File: hw/rtl/pps_pkg.sv
// Shared constants and field layout for the pixel plane store.
`timescale 1ns / 1ps

package pps_pkg;

    // Box bounds, effective screen size and on-screen coordinates fit in one byte.
    localparam int DIM_W = 8;

    // Request codes.
    localparam logic [2:0] REQ_SET   = 3'd0;
    localparam logic [2:0] REQ_CLEAR = 3'd1;
    localparam logic [2:0] REQ_COPY  = 3'd2;
    localparam logic [2:0] REQ_QUERY = 3'd3;
    localparam logic [2:0] REQ_BOX   = 3'd4;

    // Plane codes; the fourth code selects nothing.
    localparam logic [1:0] PLANE_CURRENT    = 2'd0;
    localparam logic [1:0] PLANE_PREVIOUS   = 2'd1;
    localparam logic [1:0] PLANE_PERSISTENT = 2'd2;
    localparam logic [1:0] PLANE_NONE       = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam int FLAG_W   = 3;
    localparam int CFG_W    = 6;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

endpackage

// File: hw/rtl/pps_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module pps_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/pixel_plane_store.sv
// Top level of the pixel plane store: request sequencer around one flag memory.
`timescale 1ns / 1ps

// Pixel plane store. Every pixel of a MAX_WIDTH x MAX_HEIGHT dot matrix keeps
// three flags (current, previous, persistent) in one synchronous RAM entry at
// x*height+y. After reset a clearing pass writes zeros to all
// MAX_WIDTH*MAX_HEIGHT entries, one per cycle, with s_tready low; the
// configuration port is live throughout. A set, clear, copy or query item
// does the address multiply and RAM read in the accept cycle, and the
// modify, write-back and result load in ST_MOD once the output register is
// free. An item whose coordinates lie off the screen, an empty box, or an
// item with an unused request code goes through ST_RES and touches no
// memory. A box clear reads each on-screen pixel of the box in ST_BRD and
// writes it back in ST_BWR, column by column. Every item returns exactly one
// result; the next item is accepted while a result still waits on m_tdata.
// Write the column and row count registers only while the block is idle.
module pixel_plane_store #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [pps_pkg::CFG_W-1:0]     cfg_wdata,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // req_type[2:0], x[18:3], y[34:19], plane[36:35], box_left[44:37],
    // box_right[52:45], box_top[60:53], box_bottom[68:61],
    // clear_persistent[69], zeros[71:70]
    input  logic [pps_pkg::S_DATA_W-1:0]  s_tdata,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // flag_value[0], out_of_range[1], zeros[7:2]
    output logic [pps_pkg::M_DATA_W-1:0]  m_tdata
);

    import pps_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        ST_CLR  = 6'b000001,  // clearing pass after reset
        ST_IDLE = 6'b000010,  // take an item
        ST_MOD  = 6'b000100,  // modify and write back one pixel
        ST_BRD  = 6'b001000,  // box walk: read a pixel
        ST_BWR  = 6'b010000,  // box walk: write it back
        ST_RES  = 6'b100000   // hand over a result with no memory work
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;

    // Clearing pass.
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Item fields.
    logic [2:0]       in_req;
    logic [15:0]      in_x, in_y;
    logic [1:0]       in_plane;
    logic [DIM_W-1:0] in_left, in_right, in_top, in_bottom;
    logic             in_clrp;

    // Held item state.
    logic [2:0]       req_reg;
    logic [1:0]       plane_reg;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [DIM_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [DIM_W-1:0] col_end_reg, row_end_reg, top_reg;
    logic             clrp_reg;
    logic             res_oor_reg, res_oor_next;

    // Output register.
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_flag_reg, out_oor_reg;
    logic             load_out, load_flag, load_oor;

    // Datapath.
    logic             on_screen;
    logic [DIM_W-1:0] col_end, row_end;
    logic             box_empty;
    logic [DIM_W-1:0] mul_a, add_b;
    logic [2*DIM_W:0] pix_index;
    logic [AW-1:0]    pix_addr;
    logic             accept;
    logic             can_emit;

    // Memory port.
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [FLAG_W-1:0] ram_wdata, ram_rdata;

    // Pixel modify.
    logic [FLAG_W-1:0] plane_mask;
    logic [FLAG_W-1:0] mod_data, box_data;
    logic              mod_we, mod_flag;

    assign in_req    = s_tdata[2:0];
    assign in_x      = s_tdata[18:3];
    assign in_y      = s_tdata[34:19];
    assign in_plane  = s_tdata[36:35];
    assign in_left   = s_tdata[44:37];
    assign in_right  = s_tdata[52:45];
    assign in_top    = s_tdata[60:53];
    assign in_bottom = s_tdata[68:61];
    assign in_clrp   = s_tdata[69];

    // Clamp the screen size to the store's dimensions.
    assign eff_w = ({2'b00, width_reg} > DIM_W'(MAX_WIDTH))
                 ? DIM_W'(MAX_WIDTH) : {2'b00, width_reg};
    assign eff_h = ({2'b00, height_reg} > DIM_W'(MAX_HEIGHT))
                 ? DIM_W'(MAX_HEIGHT) : {2'b00, height_reg};

    // Sign bit clear and below the size: on the screen.
    assign on_screen = !in_x[15] && !in_y[15]
                    && (in_x < {8'h00, eff_w}) && (in_y < {8'h00, eff_h});

    // Clip the box to the screen so that off-screen pixels are skipped.
    assign col_end   = (in_right < eff_w) ? in_right : eff_w;
    assign row_end   = (in_bottom < eff_h) ? in_bottom : eff_h;
    assign box_empty = (in_left >= col_end) || (in_top >= row_end);

    // Entry address: column times stride plus row, shared by the accept cycle and the box walk.
    assign mul_a     = (state_reg == ST_BRD) ? col_reg : in_x[DIM_W-1:0];
    assign add_b     = (state_reg == ST_BRD) ? row_reg : in_y[DIM_W-1:0];
    assign pix_index = (2*DIM_W+1)'(mul_a * eff_h) + (2*DIM_W+1)'(add_b);
    assign pix_addr  = pix_index[AW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign can_emit = !m_tvalid_reg || m_tready;

    // Single-pixel modify on the word just read.
    assign plane_mask = (plane_reg == PLANE_NONE) ? '0 : (FLAG_W'(1) << plane_reg);

    always_comb begin
        mod_we   = 1'b0;
        mod_data = ram_rdata;
        mod_flag = 1'b0;
        unique case (req_reg)
            REQ_SET: begin
                mod_we   = 1'b1;
                mod_data = ram_rdata | plane_mask;
            end
            REQ_CLEAR: begin
                // The persistent flag holds the current flag.
                if (!(plane_reg == PLANE_CURRENT && ram_rdata[2])) begin
                    mod_we   = 1'b1;
                    mod_data = ram_rdata & ~plane_mask;
                end
            end
            REQ_COPY: begin
                mod_we   = 1'b1;
                mod_data = {ram_rdata[2], ram_rdata[0], ram_rdata[0]};
            end
            REQ_QUERY: begin
                mod_flag = |(ram_rdata & plane_mask);
            end
            default: begin
            end
        endcase
    end

    // Box pixel: drop persistent first if asked, then current unless persistent.
    always_comb begin
        if (clrp_reg) begin
            box_data = ram_rdata & 3'b010;
        end else if (ram_rdata[2]) begin
            box_data = ram_rdata;
        end else begin
            box_data = ram_rdata & 3'b110;
        end
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        addr_next     = addr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        res_oor_next  = res_oor_reg;
        m_tvalid_next = m_tvalid_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = mod_data;
        ram_re        = 1'b0;
        load_out      = 1'b0;
        load_flag     = 1'b0;
        load_oor      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_oor_next = 1'b0;
                    addr_next    = pix_addr;
                    col_next     = in_left;
                    row_next     = in_top;
                    if (in_req <= REQ_QUERY) begin
                        if (on_screen) begin
                            ram_re     = 1'b1;
                            state_next = ST_MOD;
                        end else begin
                            res_oor_next = 1'b1;
                            state_next   = ST_RES;
                        end
                    end else if (in_req == REQ_BOX && !box_empty) begin
                        state_next = ST_BRD;
                    end else begin
                        state_next = ST_RES;
                    end
                end
            end
            ST_MOD: begin
                // Hold the read word until the output register frees up.
                if (can_emit) begin
                    ram_we        = mod_we;
                    load_out      = 1'b1;
                    load_flag     = mod_flag;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_BRD: begin
                ram_re     = 1'b1;
                addr_next  = pix_addr;
                state_next = ST_BWR;
            end
            ST_BWR: begin
                ram_we     = 1'b1;
                ram_wdata  = box_data;
                state_next = ST_BRD;
                if (row_reg + DIM_W'(1) == row_end_reg) begin
                    row_next = top_reg;
                    col_next = col_reg + DIM_W'(1);
                    if (col_reg + DIM_W'(1) == col_end_reg) begin
                        state_next = ST_RES;
                    end
                end else begin
                    row_next = row_reg + DIM_W'(1);
                end
            end
            ST_RES: begin
                if (can_emit) begin
                    load_out      = 1'b1;
                    load_oor      = res_oor_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            width_reg    <= CFG_W'(32);
            height_reg   <= CFG_W'(32);
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_COLS: width_reg  <= cfg_wdata;
                    CFG_ROWS: height_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        res_oor_reg <= res_oor_next;
        if (accept) begin
            req_reg     <= in_req;
            plane_reg   <= in_plane;
            col_end_reg <= col_end;
            row_end_reg <= row_end;
            top_reg     <= in_top;
            clrp_reg    <= in_clrp;
        end
        if (load_out) begin
            out_flag_reg <= load_flag;
            out_oor_reg  <= load_oor;
        end
    end

    pps_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (DEPTH)
    ) u_flags (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pix_addr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_DATA_W-2)'(0), out_oor_reg, out_flag_reg};

endmodule
